// ----- src/rfud_pkg.sv -----
// Shared constants, types and helper functions for the UART frame deframer.
package rfud_pkg;

  // Frame geometry: one command code plus an optional fixed-length payload.
  localparam int PAYLOAD_BYTES = 9;
  localparam int FRAME_MAX     = PAYLOAD_BYTES + 1;
  localparam int CNT_W         = $clog2(FRAME_MAX + 1);
  localparam int IDX_W         = $clog2(FRAME_MAX);
  localparam int POS_W         = 4;

  // Framing and command codes.
  localparam logic [7:0] START_CODE = 8'hAA;
  localparam logic [7:0] STOP_CODE  = 8'h55;
  localparam logic [7:0] ACK_CODE_A = 8'hA2;
  localparam logic [7:0] ACK_CODE_B = 8'hA3;
  localparam logic [7:0] ACK_CODE_C = 8'hA4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_pos;
    logic store_byte;
    logic start_emit;
    logic emit_load;
  } rfud_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic stop_ok;
    logic full;
    logic last_load;
    logic out_free;
  } rfud_stat_t;

  // Command codes that ask for an acknowledgement.
  function automatic logic code_needs_ack(input logic [7:0] code);
    logic ack;
    case (code) inside
      ACK_CODE_A, ACK_CODE_B, ACK_CODE_C: ack = 1'b1;
      default:                            ack = 1'b0;
    endcase
    return ack;
  endfunction

endpackage

// ----- src/rfud_dpath.sv -----
// Datapath of the UART frame deframer: frame store, counters and output register.
module rfud_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rfud_pkg::rfud_cmd_t       cmd,
  output rfud_pkg::rfud_stat_t      stat,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_frame_byte,
  output logic [rfud_pkg::POS_W-1:0] out_byte_position,
  output logic                      out_last_byte,
  output logic                      out_has_payload,
  output logic                      out_ack_needed
);
  import rfud_pkg::*;

  logic [7:0]       store_r [FRAME_MAX];
  logic [CNT_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       frame_byte_r;
  logic [POS_W-1:0] pos_r;
  logic             last_r, payload_r, ack_r;
  logic             full;
  logic             last_load;

  // Status decode for the controller.
  assign full      = (wp_r == CNT_W'(FRAME_MAX));
  assign last_load = ((rd_r + CNT_W'(1)) == wp_r);

  always_comb begin
    stat.is_start  = (rx_byte == START_CODE);
    stat.stop_ok   = (rx_byte == STOP_CODE) && ((wp_r == CNT_W'(1)) || full);
    stat.full      = full;
    stat.last_load = last_load;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Write position and read index.
  always_comb begin
    wp_nxt = wp_r;
    if (cmd.clear_pos) begin
      wp_nxt = '0;
    end else if (cmd.store_byte) begin
      wp_nxt = wp_r + CNT_W'(1);
    end
    rd_nxt = rd_r;
    if (cmd.start_emit) begin
      rd_nxt = '0;
    end else if (cmd.emit_load) begin
      rd_nxt = rd_r + CNT_W'(1);
    end
  end

  // The output register is full after a load and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame store: written at the write position, read at the read index.
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      store_r[wp_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      frame_byte_r <= store_r[rd_r[IDX_W-1:0]];
      pos_r        <= POS_W'(rd_r);
      last_r       <= last_load;
      payload_r    <= full;
      ack_r        <= code_needs_ack(store_r[0]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_byte    = frame_byte_r;
  assign out_byte_position = pos_r;
  assign out_last_byte     = last_r;
  assign out_has_payload   = payload_r;
  assign out_ack_needed    = ack_r;

  // The store is never written past its end, and reads stay inside the frame.
  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_byte |-> !full)
    else $error("frame store written beyond its last entry");

  a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (rd_r < wp_r))
    else $error("frame byte read beyond the stored count");

endmodule

// ----- src/rfud_ctrl.sv -----
// Controller state machine of the UART frame deframer.
module rfud_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rfud_pkg::rfud_stat_t stat,
  output rfud_pkg::rfud_cmd_t  cmd
);
  import rfud_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RECV = 3'b010,
    S_EMIT = 3'b100
  } rfud_state_t;

  rfud_state_t state_r, state_nxt;
  logic        accept;

  // Input words are refused only while a closed frame drains.
  assign in_stall = (state_r == S_EMIT);
  assign accept   = in_valid && !in_stall;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && stat.is_start) begin
          cmd.clear_pos = 1'b1;
          state_nxt     = S_RECV;
        end
      end
      S_RECV: begin
        if (accept) begin
          if (stat.stop_ok) begin
            cmd.start_emit = 1'b1;
            state_nxt      = S_EMIT;
          end else if (!stat.full) begin
            cmd.store_byte = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.last_load) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Loads happen only while draining, and the last load ends the drain.
  a_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (state_r == S_EMIT))
    else $error("output load outside the drain state");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && stat.last_load) |=> (state_r == S_IDLE))
    else $error("drain did not end after the last byte");

  a_close_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_emit |=> (state_r == S_EMIT) && in_stall)
    else $error("closed frame did not start draining");

endmodule

// ----- src/rf_uart_frame_deframer_unit.sv -----
// Top level of the UART start/stop byte frame deframer.
//
// The input channel takes one received serial byte per word (in_rx_byte).
// The start byte 0xAA opens a frame when idle; later bytes are stored in
// order. A stop byte 0x55 closes the frame when exactly one byte or a full
// code-plus-payload frame has been stored; otherwise it is stored as data.
// A further non-stop byte on a full frame drops it silently.
// A closed frame leaves on the result channel as one word per stored byte,
// each carrying its position, a last marker, the payload flag and the
// acknowledge flag derived from the command code.
// After the stop byte is accepted, the controller enters its drain state
// and the first byte is then loaded into the output register; bytes follow
// one per cycle when the receiver does not stall. The drain is paced by the
// single-word output register.
// Throughput: one input word per cycle while receiving; in_stall is high
// for the whole drain.
// When out_stall is high the output word holds and the drain pauses.
// Reset returns the block to idle with no frame open and nothing pending.
module rf_uart_frame_deframer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_frame_byte,
  output logic [rfud_pkg::POS_W-1:0] out_byte_position,
  output logic                       out_last_byte,
  output logic                       out_has_payload,
  output logic                       out_ack_needed
);
  import rfud_pkg::*;

  rfud_cmd_t  cmd;
  rfud_stat_t stat;

  // Sequencing of receive and drain.
  rfud_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Frame storage and output word.
  rfud_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .rx_byte           (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte),
    .out_has_payload   (out_has_payload),
    .out_ack_needed    (out_ack_needed)
  );

endmodule

// ----- tb/sv/rf_uart_frame_deframer_unit_tb.sv -----
// Self-checking testbench for the UART start/stop byte frame deframer.
`timescale 1ns / 100ps

module rf_uart_frame_deframer_unit_tb;
  import rfud_pkg::*;

  // One emitted frame word as the result channel presents it.
  typedef struct {
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] byte_position;
    logic             last_byte;
    logic             has_payload;
    logic             ack_needed;
  } frame_word_t;

  localparam int RANDOM_BYTES = 110;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_frame_byte;
  logic [POS_W-1:0]     out_byte_position;
  logic                 out_last_byte;
  logic                 out_has_payload;
  logic                 out_ack_needed;

  // Bytes waiting to be sent and frame words waiting to come out.
  logic [7:0]           rx_bytes_q[$];
  frame_word_t          frame_words_q[$];
  int                   total_bytes;
  int                   counted_bytes;
  int                   error_count;
  int                   words_seen;
  int                   send_gap;
  int                   stall_left;
  logic                 quiet_phase = 1'b0;

  // Shadow state of the deframer.
  logic                 shadow_open;
  int                   shadow_count;
  logic [7:0]           shadow_store[FRAME_MAX];

  rf_uart_frame_deframer_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_last_byte     (out_last_byte),
    .out_has_payload   (out_has_payload),
    .out_ack_needed    (out_ack_needed)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic wants_ack(input logic [7:0] code);
    return (code == ACK_CODE_A) || (code == ACK_CODE_B) || (code == ACK_CODE_C);
  endfunction

  // Advances the shadow deframer by one received byte and queues any frame
  // words that it closes.
  task automatic predict_frame_words(input logic [7:0] rx);
    frame_word_t w;
    if (shadow_open) begin
      if (rx == STOP_CODE && (shadow_count == 1 || shadow_count == FRAME_MAX)) begin
        for (int k = 0; k < shadow_count; k++) begin
          w.frame_byte    = shadow_store[k];
          w.byte_position = POS_W'(k);
          w.last_byte     = (k + 1 == shadow_count);
          w.has_payload   = (shadow_count == FRAME_MAX);
          w.ack_needed    = wants_ack(shadow_store[0]);
          frame_words_q.push_back(w);
        end
        shadow_open = 1'b0;
      end else if (shadow_count < FRAME_MAX) begin
        shadow_store[shadow_count] = rx;
        shadow_count++;
      end else begin
        // Overlong frame: the byte is thrown away along with the frame.
        shadow_open = 1'b0;
      end
    end else if (rx == START_CODE) begin
      shadow_count = 0;
      shadow_open  = 1'b1;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input bit counts);
    rx_bytes_q.push_back(b);
    if (counts) counted_bytes++;
  endtask

  // A command code biased towards the codes that change the flags.
  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0:       c = ACK_CODE_A;
      1:       c = ACK_CODE_B;
      2:       c = ACK_CODE_C;
      3:       c = $urandom_range(0, 1) ? 8'hA1 : 8'hA5;
      4:       c = STOP_CODE;
      5:       c = START_CODE;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  // A frame byte at the given count; a stop byte at count one would close
  // the frame early, so it is avoided there.
  function automatic logic [7:0] pick_data(input int count);
    logic [7:0] d;
    case ($urandom_range(0, 7))
      0:       d = STOP_CODE;
      1:       d = START_CODE;
      default: d = 8'($urandom_range(0, 255));
    endcase
    if (count == 1 && d == STOP_CODE) d = 8'h54;
    return d;
  endfunction

  // A well-formed frame, code only or code plus payload.
  task automatic push_frame(input bit with_payload);
    push_byte(START_CODE, 1'b1);
    push_byte(pick_code(), 1'b1);
    if (with_payload) begin
      for (int k = 1; k < FRAME_MAX; k++) push_byte(pick_data(k), 1'b1);
    end
    push_byte(STOP_CODE, 1'b1);
  endtask

  // A frame that runs past its full length and is dropped.
  task automatic push_overlong();
    logic [7:0] tail;
    push_byte(START_CODE, 1'b1);
    push_byte(pick_code(), 1'b1);
    for (int k = 1; k < FRAME_MAX; k++) push_byte(pick_data(k), 1'b1);
    tail = 8'($urandom_range(0, 255));
    if (tail == STOP_CODE) tail = 8'h56;
    push_byte(tail, 1'b1);
  endtask

  // Stimulus, then wait for the last frame to drain.
  initial begin
    int kind;
    int noise_len;
    logic [7:0] noise;
    counted_bytes = 0;
    error_count   = 0;
    words_seen    = 0;
    send_gap      = 0;
    stall_left    = 0;
    shadow_open   = 1'b0;
    shadow_count  = 0;

    // Directed part: an ignored byte while idle, a short frame with an
    // acknowledge code, an empty frame whose code is the stop byte, a full
    // frame holding stray start and stop bytes, and an overlong frame.
    rx_bytes_q = '{8'hFF,
                   START_CODE, ACK_CODE_A, STOP_CODE,
                   START_CODE, STOP_CODE, STOP_CODE,
                   START_CODE, ACK_CODE_B, 8'h00, STOP_CODE, 8'hFF, START_CODE,
                   8'h11, 8'h22, 8'h33, 8'h44, 8'h66, STOP_CODE,
                   START_CODE, ACK_CODE_C, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
                   8'h06, 8'h07, 8'h08, 8'h09, 8'h80};
    counted_bytes = rx_bytes_q.size() - 1;

    // Random part: mostly well-formed frames, with idle noise and drops.
    while (counted_bytes < RANDOM_BYTES) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        push_frame($urandom_range(0, 1));
      end else if (kind < 17) begin
        noise_len = $urandom_range(1, 4);
        for (int k = 0; k < noise_len; k++) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == START_CODE) noise = 8'hAB;
          push_byte(noise, 1'b0);
        end
      end else begin
        push_overlong();
      end
    end
    total_bytes = rx_bytes_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (frame_words_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: presents one byte per word, with random gaps until the tail.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_frame_words(in_rx_byte);
      if (rx_bytes_q.size() < total_bytes / 6) quiet_phase <= 1'b1;
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_bytes_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
        end
      end
    end
  end

  // Monitor: checks each accepted frame word and stalls in random bursts.
  always @(posedge clk) begin
    frame_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (frame_words_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: word %0d arrived with none expected: byte %02h pos %0d",
                     words_seen, out_frame_byte, out_byte_position);
        end else begin
          exp_w = frame_words_q.pop_front();
          if (out_frame_byte !== exp_w.frame_byte ||
              out_byte_position !== exp_w.byte_position ||
              out_last_byte !== exp_w.last_byte ||
              out_has_payload !== exp_w.has_payload ||
              out_ack_needed !== exp_w.ack_needed) begin
            error_count++;
            if (error_count <= 10)
              $display({"ERROR: word %0d expected byte %02h pos %0d last %0b pay %0b ",
                        "ack %0b, got byte %02h pos %0d last %0b pay %0b ack %0b"},
                       words_seen, exp_w.frame_byte, exp_w.byte_position,
                       exp_w.last_byte, exp_w.has_payload, exp_w.ack_needed,
                       out_frame_byte, out_byte_position, out_last_byte,
                       out_has_payload, out_ack_needed);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
src/rfud_pkg.sv
src/rfud_dpath.sv
src/rfud_ctrl.sv
src/rf_uart_frame_deframer_unit.sv
tb/sv/rf_uart_frame_deframer_unit_tb.sv
